// File: rtl/core/kfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyframe linear reducer.
// No dependencies; used by kfr_track, kfr_queue and the top level.
package kfr_pkg;

  localparam int SAMPLE_W       = 32;   // signed Q16.16 channel value
  localparam int CHANNELS       = 4;    // x, y, z, rotation
  localparam int GAP_W          = 8;
  localparam int GAP_LIMIT      = 255;  // a key is forced at this distance
  localparam int SENS_W         = 32;
  localparam int FRAME_BITS_DEF = 16;
  localparam logic [SENS_W-1:0] SENS_RESET = 32'd655;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Channel order inside a sample vector
  localparam int CH_X   = 0;
  localparam int CH_Y   = 1;
  localparam int CH_Z   = 2;
  localparam int CH_ROT = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One emitted key frame
  typedef struct packed {
    sample_t          x;
    sample_t          y;
    sample_t          z;
    sample_t          rot;
    logic [GAP_W-1:0] gap;
    logic             closing;
    logic             last;
  } key_t;

  // Keys produced by one frame, in order; cnt is 0, 1 or 2
  typedef struct packed {
    logic [1:0]     cnt;
    key_t [1:0]     ent;
  } push_t;

endpackage

// File: rtl/core/kfr_track.sv
`timescale 1ns / 1ps
// Per-frame key decision: previous frame, reference slopes, frame counters.
// Depends on kfr_pkg.
module kfr_track #(
  parameter int FRAME_BITS = kfr_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  kfr_pkg::sample_t              cur_i [kfr_pkg::CHANNELS],
  input  logic                          final_i,
  input  logic [kfr_pkg::SENS_W-1:0]    sensitivity_i,
  output kfr_pkg::push_t                push_o
);

  localparam int SW    = kfr_pkg::SAMPLE_W;
  localparam int MAG_W = SW + 2;
  localparam int SUM_W = SW + 4;

  // Stream state
  kfr_pkg::sample_t        prev_q [kfr_pkg::CHANNELS];
  kfr_pkg::sample_t        prev_d [kfr_pkg::CHANNELS];
  logic signed [SW:0]      ref_q  [kfr_pkg::CHANNELS];
  logic signed [SW:0]      ref_d  [kfr_pkg::CHANNELS];
  logic                    have_ref_q, have_ref_d;
  logic                    have_prev_q, have_prev_d;
  logic [FRAME_BITS-1:0]   frame_idx_q, frame_idx_d;
  logic [FRAME_BITS-1:0]   last_key_q, last_key_d;

  // Datapath
  logic signed [SW:0]      slope [kfr_pkg::CHANNELS];
  logic signed [SW+1:0]    diff  [kfr_pkg::CHANNELS];
  logic [MAG_W-1:0]        mag   [kfr_pkg::CHANNELS];
  logic [SUM_W-1:0]        total;
  logic [FRAME_BITS-1:0]   prev_idx;
  logic [FRAME_BITS-1:0]   key_dist;
  logic [FRAME_BITS-1:0]   last_key_nx;
  logic [FRAME_BITS-1:0]   final_gap;
  logic                    key;
  logic                    emit_prev;
  kfr_pkg::key_t           prev_key;
  kfr_pkg::key_t           close_key;

  // Slope change against the reference, summed over channels
  always_comb begin
    total = '0;
    for (int c = 0; c < kfr_pkg::CHANNELS; c++) begin
      slope[c] = $signed({cur_i[c][SW-1], cur_i[c]}) - $signed({prev_q[c][SW-1], prev_q[c]});
      diff[c]  = $signed({slope[c][SW], slope[c]}) - $signed({ref_q[c][SW], ref_q[c]});
      mag[c]   = diff[c][SW+1] ? MAG_W'(-diff[c]) : MAG_W'(diff[c]);
      total    = total + SUM_W'(mag[c]);
    end
  end

  // Key decision for the previous frame and the keys this frame emits
  always_comb begin
    prev_idx    = frame_idx_q - FRAME_BITS'(1);
    key_dist    = prev_idx - last_key_q;
    key         = !have_ref_q || (total >= SUM_W'(sensitivity_i)) ||
                  (key_dist >= FRAME_BITS'(kfr_pkg::GAP_LIMIT));
    emit_prev   = have_prev_q && key;
    last_key_nx = emit_prev ? prev_idx : last_key_q;
    final_gap   = have_prev_q ? (frame_idx_q - last_key_nx) : '0;

    prev_key.x       = prev_q[kfr_pkg::CH_X];
    prev_key.y       = prev_q[kfr_pkg::CH_Y];
    prev_key.z       = prev_q[kfr_pkg::CH_Z];
    prev_key.rot     = prev_q[kfr_pkg::CH_ROT];
    prev_key.gap     = have_ref_q ? key_dist[kfr_pkg::GAP_W-1:0] : '0;
    prev_key.closing = 1'b0;
    prev_key.last    = !final_i;

    close_key.x       = cur_i[kfr_pkg::CH_X];
    close_key.y       = cur_i[kfr_pkg::CH_Y];
    close_key.z       = cur_i[kfr_pkg::CH_Z];
    close_key.rot     = cur_i[kfr_pkg::CH_ROT];
    close_key.gap     = final_gap[kfr_pkg::GAP_W-1:0];
    close_key.closing = 1'b1;
    close_key.last    = 1'b1;

    push_o.ent = {close_key, prev_key};
    push_o.cnt = 2'd0;
    if (emit_prev) begin
      push_o.ent[0] = prev_key;
      push_o.ent[1] = close_key;
      push_o.cnt    = final_i ? 2'd2 : 2'd1;
    end else if (final_i) begin
      push_o.ent[0] = close_key;
      push_o.cnt    = 2'd1;
    end
  end

  // Next state on an accepted frame
  always_comb begin
    prev_d      = prev_q;
    ref_d       = ref_q;
    have_ref_d  = have_ref_q;
    have_prev_d = have_prev_q;
    frame_idx_d = frame_idx_q;
    last_key_d  = last_key_q;
    if (accept_i) begin
      if (final_i) begin
        // animation ends: back to the start-of-stream state
        have_ref_d  = 1'b0;
        have_prev_d = 1'b0;
        frame_idx_d = '0;
        last_key_d  = '0;
      end else begin
        if (emit_prev) begin
          ref_d      = slope;
          have_ref_d = 1'b1;
        end
        prev_d      = cur_i;
        have_prev_d = 1'b1;
        frame_idx_d = frame_idx_q + FRAME_BITS'(1);
        last_key_d  = last_key_nx;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_ref_q  <= 1'b0;
      have_prev_q <= 1'b0;
      frame_idx_q <= '0;
      last_key_q  <= '0;
    end else begin
      have_ref_q  <= have_ref_d;
      have_prev_q <= have_prev_d;
      frame_idx_q <= frame_idx_d;
      last_key_q  <= last_key_d;
    end
  end

  // Sample and slope storage, only read once the matching flag is set
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    ref_q  <= ref_d;
  end

`ifndef SYNTH
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && final_i |=> !have_prev_q && !have_ref_q && frame_idx_q == '0)
    else $error("stream state not cleared after final frame");

  a_two_needs_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> final_i && have_prev_q)
    else $error("two keys from a frame that is not final");

  a_ref_needs_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_ref_q |-> have_prev_q)
    else $error("reference slope without previous frame");
`endif

endmodule

// File: rtl/core/kfr_queue.sv
`timescale 1ns / 1ps
// Small shifting result queue: up to two words in per cycle, one word out.
// Depends on kfr_pkg.
module kfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kfr_pkg::push_t  push_data_i,
  input  logic            pop_i,
  output kfr_pkg::key_t   head_o,
  output logic            valid_o,
  output logic            room_o
);

  localparam int D = kfr_pkg::Q_DEPTH;

  kfr_pkg::key_t                 ent_q [D];
  kfr_pkg::key_t                 ent_d [D];
  logic [kfr_pkg::Q_CNT_W-1:0]   count_q, count_d;
  logic [kfr_pkg::Q_CNT_W-1:0]   base;
  logic [kfr_pkg::Q_CNT_W-1:0]   n_in;
  logic [kfr_pkg::Q_IDX_W-1:0]   idx0, idx1;

  // Shift out the head, then append the new words behind the survivors
  always_comb begin
    ent_d = ent_q;
    if (pop_i) begin
      for (int i = 0; i < D - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    base = count_q - kfr_pkg::Q_CNT_W'(pop_i);
    n_in = push_i ? kfr_pkg::Q_CNT_W'(push_data_i.cnt) : '0;
    idx0 = base[kfr_pkg::Q_IDX_W-1:0];
    idx1 = idx0 + kfr_pkg::Q_IDX_W'(1);
    if (n_in != '0) begin
      ent_d[idx0] = push_data_i.ent[0];
    end
    if (n_in == kfr_pkg::Q_CNT_W'(2)) begin
      ent_d[idx1] = push_data_i.ent[1];
    end
    count_d = base + n_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o  = ent_q[0];
  assign valid_o = (count_q != '0);
  // room for the two words a final frame can bring
  assign room_o  = (count_q <= kfr_pkg::Q_CNT_W'(D - 2));

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kfr_pkg::Q_CNT_W'(D))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && push_data_i.cnt != 2'd0 |-> count_q <= kfr_pkg::Q_CNT_W'(D - 2))
    else $error("push into a queue without room");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");
`endif

endmodule

// File: rtl/core/keyframe_linear_reducer_top.sv
`timescale 1ns / 1ps
// Frame f is judged when frame f+1 is accepted (a final frame is keyed at once); the
// key words enter the registered result queue. One frame is taken per cycle unless
// the input stalls; a final frame may yield two keys, which leave one per cycle
// unless the output stalls, through a four-word result queue. Input stalls while
// fewer than two queue words are free. Reset (async, active low) clears the stream state
// and the queue and sets sensitivity to 655. Depends on kfr_pkg, kfr_track, kfr_queue.
module keyframe_linear_reducer_top #(
  parameter int FRAME_BITS = kfr_pkg::FRAME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // frame input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kfr_pkg::sample_t            sample_x_i,
  input  kfr_pkg::sample_t            sample_y_i,
  input  kfr_pkg::sample_t            sample_z_i,
  input  kfr_pkg::sample_t            sample_rot_i,
  input  logic                        final_frame_i,
  // key output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kfr_pkg::sample_t            key_x_o,
  output kfr_pkg::sample_t            key_y_o,
  output kfr_pkg::sample_t            key_z_o,
  output kfr_pkg::sample_t            key_rot_o,
  output logic [kfr_pkg::GAP_W-1:0]   gap_o,
  output logic                        closing_key_o,
  output logic                        last_of_run_o,
  // sensitivity write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kfr_pkg::SENS_W-1:0]  cfg_data_i
);

  logic [kfr_pkg::SENS_W-1:0] sens_q;
  logic                       in_accept;
  logic                       pop;
  logic                       room;
  kfr_pkg::sample_t           cur [kfr_pkg::CHANNELS];
  kfr_pkg::push_t             push_data;
  kfr_pkg::key_t              head;

  // Sensitivity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= kfr_pkg::SENS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sens_q <= cfg_data_i;
    end
  end

  // Input handshake
  assign in_stall_o = !room;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cur[kfr_pkg::CH_X]   = sample_x_i;
  assign cur[kfr_pkg::CH_Y]   = sample_y_i;
  assign cur[kfr_pkg::CH_Z]   = sample_z_i;
  assign cur[kfr_pkg::CH_ROT] = sample_rot_i;

  kfr_track #(
    .FRAME_BITS (FRAME_BITS)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .cur_i         (cur),
    .final_i       (final_frame_i),
    .sensitivity_i (sens_q),
    .push_o        (push_data)
  );

  // Output word queue
  assign pop = out_valid_o && !out_stall_i;

  kfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (out_valid_o),
    .room_o      (room)
  );

  assign key_x_o       = head.x;
  assign key_y_o       = head.y;
  assign key_z_o       = head.z;
  assign key_rot_o     = head.rot;
  assign gap_o         = head.gap;
  assign closing_key_o = head.closing;
  assign last_of_run_o = head.last;

endmodule

// File: bench/tb_keyframe_linear_reducer_top.sv
`timescale 1ns / 1ps
// Self-checking bench for keyframe_linear_reducer_top: frame streams in, key words out.
// Depends on kfr_pkg and the reducer RTL; keeps its own model of key selection.
module tb_keyframe_linear_reducer_top;

  localparam int FB         = kfr_pkg::FRAME_BITS_DEF;
  localparam int CYCLE_CAP  = 1_500_000;
  localparam int SHOW_ERRS  = 10;

  typedef logic signed [kfr_pkg::SAMPLE_W:0] slope_t;
  typedef enum int {MOTION_SMOOTH, MOTION_NOISE, MOTION_STILL} motion_e;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  kfr_pkg::sample_t            sample_x_i    = '0;
  kfr_pkg::sample_t            sample_y_i    = '0;
  kfr_pkg::sample_t            sample_z_i    = '0;
  kfr_pkg::sample_t            sample_rot_i  = '0;
  logic                        final_frame_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  kfr_pkg::sample_t            key_x_o;
  kfr_pkg::sample_t            key_y_o;
  kfr_pkg::sample_t            key_z_o;
  kfr_pkg::sample_t            key_rot_o;
  logic [kfr_pkg::GAP_W-1:0]   gap_o;
  logic                        closing_key_o;
  logic                        last_of_run_o;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [kfr_pkg::SENS_W-1:0]  cfg_data_i    = '0;

  keyframe_linear_reducer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .sample_z_i    (sample_z_i),
    .sample_rot_i  (sample_rot_i),
    .final_frame_i (final_frame_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_x_o       (key_x_o),
    .key_y_o       (key_y_o),
    .key_z_o       (key_z_o),
    .key_rot_o     (key_rot_o),
    .gap_o         (gap_o),
    .closing_key_o (closing_key_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Bench knobs, shared between the stimulus thread and the output side
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_left  = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Key-selection model state
  logic [kfr_pkg::SENS_W-1:0] sensitivity;
  kfr_pkg::sample_t           last_sample [kfr_pkg::CHANNELS];
  slope_t                     key_slope [kfr_pkg::CHANNELS];
  logic                       have_key;
  logic                       have_prev;
  logic [FB-1:0]              frame_count;
  logic [FB-1:0]              last_key_at;
  kfr_pkg::key_t              expected_keys [$];

  task automatic clear_animation();
    for (int c = 0; c < kfr_pkg::CHANNELS; c++) begin
      last_sample[c] = '0;
      key_slope[c]   = '0;
    end
    have_key    = 1'b0;
    have_prev   = 1'b0;
    frame_count = '0;
    last_key_at = '0;
  endtask

  // Decide which keys one accepted frame releases and queue them in order
  task automatic predict_keys(input kfr_pkg::sample_t x, input kfr_pkg::sample_t y,
                              input kfr_pkg::sample_t z, input kfr_pkg::sample_t rot,
                              input logic is_final);
    kfr_pkg::sample_t cur [kfr_pkg::CHANNELS];
    slope_t           slope [kfr_pkg::CHANNELS];
    longint           total;
    longint           diff;
    logic [FB-1:0]    prev_idx;
    logic [FB-1:0]    key_dist;
    kfr_pkg::key_t    lead;
    kfr_pkg::key_t    tail;
    logic             have_lead;
    logic             take;
    cur[kfr_pkg::CH_X]   = x;
    cur[kfr_pkg::CH_Y]   = y;
    cur[kfr_pkg::CH_Z]   = z;
    cur[kfr_pkg::CH_ROT] = rot;
    have_lead = 1'b0;
    lead = '0;
    tail = '0;
    if (have_prev) begin
      prev_idx = frame_count - FB'(1);
      key_dist = prev_idx - last_key_at;
      total    = 0;
      for (int c = 0; c < kfr_pkg::CHANNELS; c++) begin
        slope[c] = slope_t'(longint'(cur[c]) - longint'(last_sample[c]));
        diff     = longint'(slope[c]) - longint'(key_slope[c]);
        total   += (diff < 0) ? -diff : diff;
      end
      take = !have_key || total >= longint'({32'd0, sensitivity}) ||
             key_dist >= kfr_pkg::GAP_LIMIT;
      if (take) begin
        lead.x       = last_sample[kfr_pkg::CH_X];
        lead.y       = last_sample[kfr_pkg::CH_Y];
        lead.z       = last_sample[kfr_pkg::CH_Z];
        lead.rot     = last_sample[kfr_pkg::CH_ROT];
        lead.gap     = have_key ? kfr_pkg::GAP_W'(key_dist) : '0;
        lead.closing = 1'b0;
        lead.last    = 1'b0;
        have_lead    = 1'b1;
        last_key_at  = prev_idx;
        for (int c = 0; c < kfr_pkg::CHANNELS; c++) key_slope[c] = slope[c];
        have_key = 1'b1;
      end
    end
    if (is_final) begin
      tail.x       = x;
      tail.y       = y;
      tail.z       = z;
      tail.rot     = rot;
      tail.gap     = have_prev ? kfr_pkg::GAP_W'(frame_count - last_key_at) : '0;
      tail.closing = 1'b1;
      tail.last    = 1'b1;
      if (have_lead) expected_keys.push_back(lead);
      expected_keys.push_back(tail);
      clear_animation();
    end else begin
      if (have_lead) begin
        lead.last = 1'b1;
        expected_keys.push_back(lead);
      end
      for (int c = 0; c < kfr_pkg::CHANNELS; c++) last_sample[c] = cur[c];
      have_prev   = 1'b1;
      frame_count = frame_count + FB'(1);
    end
  endtask

  // Offer one frame word, with random idle cycles ahead of it; returns once accepted
  task automatic send_frame(input kfr_pkg::sample_t x, input kfr_pkg::sample_t y,
                            input kfr_pkg::sample_t z, input kfr_pkg::sample_t rot,
                            input logic is_final);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_x_i    <= x;
    sample_y_i    <= y;
    sample_z_i    <= z;
    sample_rot_i  <= rot;
    final_frame_i <= is_final;
    do @(posedge clk_i); while (in_stall_o);
    predict_keys(x, y, z, rot, is_final);
  endtask

  // Hold the input until every queued key has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sensitivity(input logic [kfr_pkg::SENS_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sensitivity = value;
  endtask

  // One animation with generated motion; the last frame carries the final mark
  task automatic play_animation(input int frames, input motion_e style);
    kfr_pkg::sample_t pos [kfr_pkg::CHANNELS];
    int               vel [kfr_pkg::CHANNELS];
    for (int c = 0; c < kfr_pkg::CHANNELS; c++) begin
      pos[c] = kfr_pkg::sample_t'($urandom);
      vel[c] = int'($urandom_range(0, 524288)) - 262144;
    end
    for (int i = 0; i < frames; i++) begin
      if (style == MOTION_NOISE) begin
        for (int c = 0; c < kfr_pkg::CHANNELS; c++) pos[c] = kfr_pkg::sample_t'($urandom);
      end else if (style == MOTION_SMOOTH) begin
        for (int c = 0; c < kfr_pkg::CHANNELS; c++) begin
          if ($urandom_range(7) == 0) vel[c] += int'($urandom_range(0, 4095)) - 2048;
          pos[c] = pos[c] + kfr_pkg::sample_t'(vel[c]);
        end
      end
      send_frame(pos[kfr_pkg::CH_X], pos[kfr_pkg::CH_Y], pos[kfr_pkg::CH_Z],
                 pos[kfr_pkg::CH_ROT], i == frames - 1);
    end
  endtask

  // Output side: check accepted key words, then choose next cycle's stall
  always @(posedge clk_i) begin
    kfr_pkg::key_t exp_key;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_keys.size() == 0) begin
        error_count++;
        if (error_count <= SHOW_ERRS)
          $display("unexpected key word: x=%h y=%h z=%h rot=%h gap=%0d close=%b last=%b",
                   key_x_o, key_y_o, key_z_o, key_rot_o, gap_o, closing_key_o,
                   last_of_run_o);
      end else begin
        exp_key = expected_keys.pop_front();
        if (key_x_o !== exp_key.x || key_y_o !== exp_key.y || key_z_o !== exp_key.z ||
            key_rot_o !== exp_key.rot || gap_o !== exp_key.gap ||
            closing_key_o !== exp_key.closing || last_of_run_o !== exp_key.last) begin
          error_count++;
          if (error_count <= SHOW_ERRS) begin
            $display("key mismatch, expected: x=%h y=%h z=%h rot=%h gap=%0d close=%b last=%b",
                     exp_key.x, exp_key.y, exp_key.z, exp_key.rot, exp_key.gap,
                     exp_key.closing, exp_key.last);
            $display("              actual: x=%h y=%h z=%h rot=%h gap=%0d close=%b last=%b",
                     key_x_o, key_y_o, key_z_o, key_rot_o, gap_o, closing_key_o,
                     last_of_run_o);
          end
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_keyframe_linear_reducer_top: done, errors");
      $finish;
    end
  end

  // Reset sensitivity: slope changes just at and just under 655
  task automatic test_reset_sensitivity();
    send_frame(32'sd0,    32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_frame(32'sd1000, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_frame(32'sd2000, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_frame(32'sd3655, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_frame(32'sd5964, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_frame(32'sd7619, 32'sd0, 32'sd0, 32'sd0, 1'b1);
  endtask

  // A final frame with nothing before it, and a two-frame animation
  task automatic test_short_animations();
    send_frame(32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 1'b1);
    send_frame(32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 32'sd0, 1'b1);
    send_frame(32'sd65536, -32'sd65536, 32'sd12345, 32'sd0, 1'b0);
    send_frame(32'sd70000, -32'sd60000, 32'sd12345, 32'sd99, 1'b1);
  endtask

  // Full-scale swings: 33-bit slopes and a sum past the largest threshold
  task automatic test_extreme_slopes();
    write_sensitivity(32'hffff_ffff);
    for (int i = 0; i < 6; i++) begin
      if (i[0])
        send_frame(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, i == 5);
      else
        send_frame(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    end
  endtask

  // Zero threshold keeps every frame, even with no motion
  task automatic test_keep_all();
    write_sensitivity(32'd0);
    for (int i = 0; i < 5; i++) send_frame(32'sd7, 32'sd7, 32'sd7, 32'sd7, i == 4);
  endtask

  // Still motion under the largest threshold: past the first key, keys come only from the 255 limit and the final frame
  task automatic test_gap_limit();
    write_sensitivity(32'hffff_ffff);
    play_animation(300, MOTION_STILL);
    play_animation(256, MOTION_STILL);
  endtask

  // Receiver holds off long while frames keep coming, then the sender waits it out
  task automatic test_backpressure();
    write_sensitivity(32'd0);
    hold_req = 200;
    play_animation(40, MOTION_NOISE);
    wait_drained();
  endtask

  task automatic run_random_phase(input int sender_pct, input int recv_pct,
                                  input logic [kfr_pkg::SENS_W-1:0] sens, input int budget);
    int sent;
    int pick;
    int frames;
    motion_e style;
    write_sensitivity(sens);
    idle_pct  = sender_pct;
    stall_pct = recv_pct;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 10)      frames = $urandom_range(1, 2);
      else if (pick < 92) frames = $urandom_range(3, 40);
      else                frames = $urandom_range(41, 300);
      pick = $urandom_range(99);
      if (pick < 70)      style = MOTION_SMOOTH;
      else if (pick < 85) style = MOTION_NOISE;
      else                style = MOTION_STILL;
      play_animation(frames, style);
      sent += frames;
    end
    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    sensitivity = kfr_pkg::SENS_RESET;
    clear_animation();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_sensitivity();
    test_short_animations();
    test_extreme_slopes();
    test_keep_all();
    test_gap_limit();
    test_backpressure();
    run_random_phase(0,  0,  32'd1500, 100);
    run_random_phase(55, 0,  32'd0, 100);
    run_random_phase(0,  55, $urandom_range(0, 4000), 100);
    run_random_phase(12, 12, 32'hffff_ffff, 100);
    run_random_phase(12, 12, $urandom, 50);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_keys.size() == 0)
      $display("tb_keyframe_linear_reducer_top: done, clean");
    else
      $display("tb_keyframe_linear_reducer_top: done, errors");
    $finish;
  end

endmodule
